// ----- hw/rtl/nwkhp_pkg.sv -----
// Shared types and constants for the network-layer header parser.
`timescale 1ns / 1ps

package nwkhp_pkg;

  localparam int FC_WIDTH = 14;
  localparam int HLEN_WIDTH = 5;

  // Byte positions and field lengths within the header.
  localparam logic [HLEN_WIDTH-1:0] POS_FC_LO = 5'd0;
  localparam logic [HLEN_WIDTH-1:0] POS_FC_HI = 5'd1;
  localparam logic [HLEN_WIDTH-1:0] POS_SHORT_END = 5'd6;
  localparam logic [HLEN_WIDTH-1:0] FIXED_LEN = 5'd8;
  localparam logic [HLEN_WIDTH-1:0] LONG_LEN = 5'd8;

  // Frame control flag bits.
  localparam int BIT_MCAST = 8;
  localparam int BIT_DST_LONG = 11;
  localparam int BIT_SRC_LONG = 12;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } nwkhp_in_t;

  typedef struct packed {
    logic [FC_WIDTH-1:0]   frame_control;
    logic [15:0]           dst_short_addr;
    logic [15:0]           src_short_addr;
    logic [7:0]            hop_radius;
    logic [7:0]            sequence_number;
    logic [63:0]           dst_long_addr;
    logic [63:0]           src_long_addr;
    logic [7:0]            mcast_control;
    logic [HLEN_WIDTH-1:0] header_length;
  } nwkhp_out_t;

endpackage

// ----- hw/rtl/nwk_header_parser.sv -----
// Top level of the network-layer header parser: byte input, result register with skid.
`timescale 1ns / 1ps

// channel  dir  handshake            word
// in       in   in_valid/in_ready    nwkhp_in_t  (data_byte, frame_start)
// out      out  out_valid/out_ready  nwkhp_out_t (all header fields, header_length)
//
// One byte is taken per cycle unless input is stalled; each result is registered on its way out.
// Bytes go straight into the field registers; one result register plus one skid
// register hold finished headers, so input stalls only when both are full.
// Reset (rst, synchronous) returns the parser to idle and empties both output stages.

module nwk_header_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  nwkhp_pkg::nwkhp_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output nwkhp_pkg::nwkhp_out_t out_data
);
  import nwkhp_pkg::*;

  logic       step, res_valid, skid_valid, load_out;
  nwkhp_out_t res_data, skid_data;

  assign in_ready = !skid_valid;
  assign step = in_valid && in_ready;
  assign load_out = !out_valid || out_ready;

  nwkhp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= skid_valid || res_valid;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= skid_valid ? skid_data : res_data;
    end else if (res_valid) begin
      skid_data <= res_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty output register");

  a_len_matches_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.header_length == FIXED_LEN
      + (out_data.frame_control[BIT_DST_LONG] ? LONG_LEN : 5'd0)
      + (out_data.frame_control[BIT_SRC_LONG] ? LONG_LEN : 5'd0)
      + {4'd0, out_data.frame_control[BIT_MCAST]})
    else $error("header length disagrees with frame control flags");

  a_absent_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.frame_control[BIT_DST_LONG] || out_data.dst_long_addr == 64'd0)
      && (out_data.frame_control[BIT_SRC_LONG] || out_data.src_long_addr == 64'd0)
      && (out_data.frame_control[BIT_MCAST] || out_data.mcast_control == 8'd0))
    else $error("absent optional field is nonzero");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_valid && !out_ready |=> skid_valid)
    else $error("result lost while output stalled");

endmodule

// ----- hw/rtl/nwkhp_parse.sv -----
// Byte-wise header field capture: position counter, field registers, result decode.
`timescale 1ns / 1ps

module nwkhp_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  nwkhp_pkg::nwkhp_in_t in_data,
  output logic                res_valid,
  output nwkhp_pkg::nwkhp_out_t res_data
);
  import nwkhp_pkg::*;

  logic [HLEN_WIDTH-1:0] byte_position, byte_position_next;
  logic                  active, active_next;
  logic [FC_WIDTH-1:0]   control_word, control_word_next;
  logic [31:0]           short_addresses, short_addresses_next;
  logic [15:0]           radius_seq, radius_seq_next;
  logic [63:0]           long_dst, long_dst_next;
  logic [63:0]           long_src, long_src_next;

  logic [HLEN_WIDTH-1:0] pos, pos_inc, soff, total;
  logic                  act, has_dst, has_src, has_mc, hit;
  logic [7:0]            b;

  always_comb begin
    b = in_data.data_byte;
    // a start word discards whatever header was in progress
    act = in_data.frame_start | active;
    pos = in_data.frame_start ? '0 : byte_position;
    control_word_next = in_data.frame_start ? '0 : control_word;
    short_addresses_next = in_data.frame_start ? '0 : short_addresses;
    radius_seq_next = in_data.frame_start ? '0 : radius_seq;
    long_dst_next = in_data.frame_start ? '0 : long_dst;
    long_src_next = in_data.frame_start ? '0 : long_src;

    has_dst = control_word_next[BIT_DST_LONG];
    has_src = control_word_next[BIT_SRC_LONG];
    soff = FIXED_LEN + (has_dst ? LONG_LEN : 5'd0);

    if (pos == POS_FC_LO) begin
      control_word_next = {{(FC_WIDTH-8){1'b0}}, b};
    end else if (pos == POS_FC_HI) begin
      control_word_next[FC_WIDTH-1:8] = b[FC_WIDTH-9:0];
    end else if (pos < POS_SHORT_END) begin
      short_addresses_next = {short_addresses_next[23:0], b};
    end else if (pos < FIXED_LEN) begin
      radius_seq_next = {radius_seq_next[7:0], b};
    end else if (has_dst && pos < FIXED_LEN + LONG_LEN) begin
      long_dst_next = {long_dst_next[55:0], b};
    end else if (has_src && pos >= soff && pos < soff + LONG_LEN) begin
      long_src_next = {long_src_next[55:0], b};
    end

    pos_inc = pos + 5'd1;
    has_mc = control_word_next[BIT_MCAST];
    total = FIXED_LEN
          + (control_word_next[BIT_DST_LONG] ? LONG_LEN : 5'd0)
          + (control_word_next[BIT_SRC_LONG] ? LONG_LEN : 5'd0)
          + {4'd0, has_mc};
    hit = act && pos_inc >= FIXED_LEN && pos_inc == total;

    byte_position_next = act ? pos_inc : byte_position;
    active_next = act && !hit;

    res_valid = step && hit;
    res_data.frame_control = control_word_next;
    res_data.dst_short_addr = short_addresses_next[31:16];
    res_data.src_short_addr = short_addresses_next[15:0];
    res_data.hop_radius = radius_seq_next[15:8];
    res_data.sequence_number = radius_seq_next[7:0];
    res_data.dst_long_addr = long_dst_next;
    res_data.src_long_addr = long_src_next;
    // the multicast byte is always the last one when present
    res_data.mcast_control = has_mc ? b : 8'd0;
    res_data.header_length = total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      active <= 1'b0;
    end else if (step) begin
      byte_position <= byte_position_next;
      active <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && act) begin
      control_word <= control_word_next;
      short_addresses <= short_addresses_next;
      radius_seq <= radius_seq_next;
      long_dst <= long_dst_next;
      long_src <= long_src_next;
    end
  end

endmodule
